// ===== src/trrf_pkg.sv =====
// Package with the types, codes and constants shared by the touch recovery block.
`default_nettype none
package trrf_pkg;

	// Panel geometry in native portrait orientation.
	localparam int PANEL_WIDTH  = 240;
	localparam int PANEL_HEIGHT = 320;

	localparam logic [15:0] RAW_X_MAX = 16'(PANEL_WIDTH - 1);
	localparam logic [15:0] RAW_Y_MAX = 16'(PANEL_HEIGHT - 1);

	// Status byte layout.
	localparam int STATUS_READY_BIT = 7;

	// Command codes.
	localparam logic CMD_POLL = 1'b0;
	localparam logic CMD_TICK = 1'b1;

	// Failure stage codes.
	localparam logic [1:0] STAGE_NONE   = 2'd0;
	localparam logic [1:0] STAGE_STATUS = 2'd1;
	localparam logic [1:0] STAGE_POINT  = 2'd2;
	localparam logic [1:0] STAGE_CLEAR  = 2'd3;

	// Configuration register indexes.
	localparam logic [1:0] REG_FAILURE_LIMIT  = 2'd0;
	localparam logic [1:0] REG_RECOVERY_LIMIT = 2'd1;
	localparam logic [1:0] REG_HOLDOFF_TICKS  = 2'd2;
	localparam logic [1:0] REG_MAX_POINTS     = 2'd3;

	// Configuration reset values.
	localparam logic [3:0]  FAILURE_LIMIT_RST  = 4'd3;
	localparam logic [3:0]  RECOVERY_LIMIT_RST = 4'd2;
	localparam logic [15:0] HOLDOFF_TICKS_RST  = 16'd2000;
	localparam logic [3:0]  MAX_POINTS_RST     = 4'd5;

	localparam logic [3:0] COUNT_SAT = 4'hF;

	typedef struct packed {
		logic        command;
		logic        status_ok;
		logic [7:0]  status_byte;
		logic        point_ok;
		logic [15:0] raw_x;
		logic [15:0] raw_y;
		logic        clear_ok;
		logic        reinit_ok;
	} in_item_t;

	typedef struct packed {
		logic [8:0] pos_x;
		logic [7:0] pos_y;
		logic       pressed;
		logic       touch_off;
		logic       recover_now;
		logic [1:0] fail_stage;
	} out_item_t;

	typedef struct packed {
		logic [1:0]  index;
		logic [15:0] value;
	} cfg_write_t;

	typedef struct packed {
		logic [3:0]  failure_limit;
		logic [3:0]  recovery_limit;
		logic [15:0] holdoff_ticks;
		logic [3:0]  max_points;
	} cfg_regs_t;

	typedef struct packed {
		logic [3:0]  fail_count;
		logic [3:0]  attempt_count;
		logic        off_flag;
		logic [15:0] holdoff_left;
		logic [8:0]  held_x;
		logic [7:0]  held_y;
		logic        held_press;
	} track_state_t;

endpackage
`default_nettype wire

// ===== src/trrf_ifs.sv =====
// Handshake interfaces for the poll, pointer and configuration channels.
`default_nettype none
interface trrf_in_if;
	import trrf_pkg::*;
	logic     valid;
	logic     ready;
	in_item_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface trrf_out_if;
	import trrf_pkg::*;
	logic      valid;
	logic      ready;
	out_item_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface trrf_cfg_if;
	import trrf_pkg::*;
	logic       valid;
	logic       ready;
	cfg_write_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== src/trrf_cfg_regs.sv =====
// Configuration register bank with its write channel.
`default_nettype none
module trrf_cfg_regs (
	input  wire logic          clk,
	input  wire logic          arst_n,
	trrf_cfg_if.sink           cfg,
	output trrf_pkg::cfg_regs_t regs
);
	import trrf_pkg::*;

	cfg_regs_t regs_q;

	assign cfg.ready = 1'b1;
	assign regs      = regs_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q.failure_limit  <= FAILURE_LIMIT_RST;
			regs_q.recovery_limit <= RECOVERY_LIMIT_RST;
			regs_q.holdoff_ticks  <= HOLDOFF_TICKS_RST;
			regs_q.max_points     <= MAX_POINTS_RST;
		end else if (cfg.valid) begin
			case (cfg.data.index)
				REG_FAILURE_LIMIT:  regs_q.failure_limit  <= cfg.data.value[3:0];
				REG_RECOVERY_LIMIT: regs_q.recovery_limit <= cfg.data.value[3:0];
				REG_HOLDOFF_TICKS:  regs_q.holdoff_ticks  <= cfg.data.value;
				REG_MAX_POINTS:     regs_q.max_points     <= cfg.data.value[3:0];
				default: begin
				end
			endcase
		end
	end
endmodule
`default_nettype wire

// ===== src/trrf_step.sv =====
// Next-state and result logic for one poll outcome or tick.
`default_nettype none
module trrf_step (
	input  wire trrf_pkg::in_item_t     item,
	input  wire trrf_pkg::cfg_regs_t    regs,
	input  wire trrf_pkg::track_state_t cur,
	output trrf_pkg::track_state_t      nxt,
	output trrf_pkg::out_item_t         res
);
	import trrf_pkg::*;

	logic [3:0]  count;
	logic        count_valid;
	logic        fail;
	logic [1:0]  stage;
	logic [3:0]  fc_inc;
	logic [3:0]  att_inc;
	logic        recovered;
	logic [15:0] cx;
	logic [15:0] cy;
	track_state_t st;

	assign count       = item.status_byte[3:0];
	assign count_valid = (count != 4'd0) && (count <= regs.max_points);
	assign fc_inc      = (cur.fail_count == COUNT_SAT) ? COUNT_SAT : cur.fail_count + 4'd1;
	assign att_inc     = cur.attempt_count + 4'd1;
	assign cx          = (item.raw_x > RAW_X_MAX) ? RAW_X_MAX : item.raw_x;
	assign cy          = (item.raw_y > RAW_Y_MAX) ? RAW_Y_MAX : item.raw_y;

	// Tick and poll outcome decode: holdoff countdown, point capture, count clearing and failure stage.
	always_comb begin
		st    = cur;
		fail  = 1'b0;
		stage = STAGE_NONE;
		if (item.command == CMD_TICK) begin
			if (cur.holdoff_left != 16'd0) begin
				st.holdoff_left = cur.holdoff_left - 16'd1;
			end
		end else if (cur.off_flag) begin
			st.held_press = 1'b0;
		end else if (!item.status_ok) begin
			fail  = 1'b1;
			stage = STAGE_STATUS;
		end else if (!item.status_byte[STATUS_READY_BIT]) begin
			st.fail_count    = 4'd0;
			st.attempt_count = 4'd0;
		end else if (count_valid && !item.point_ok) begin
			fail  = 1'b1;
			stage = STAGE_POINT;
		end else begin
			if (count_valid) begin
				st.held_y     = cx[7:0];
				st.held_x     = 9'(RAW_Y_MAX - cy);
				st.held_press = 1'b1;
			end else begin
				st.held_press = 1'b0;
			end
			if (!item.clear_ok) begin
				fail  = 1'b1;
				stage = STAGE_CLEAR;
			end else begin
				st.fail_count    = 4'd0;
				st.attempt_count = 4'd0;
			end
		end
	end

	// Failure budget and recovery decision.
	always_comb begin
		nxt       = st;
		recovered = 1'b0;
		if (fail) begin
			nxt.held_press = 1'b0;
			nxt.fail_count = fc_inc;
			if ((fc_inc >= regs.failure_limit) && (cur.holdoff_left == 16'd0)) begin
				if (cur.attempt_count >= regs.recovery_limit) begin
					nxt.off_flag = 1'b1;
				end else begin
					recovered         = 1'b1;
					nxt.attempt_count = att_inc;
					nxt.holdoff_left  = regs.holdoff_ticks;
					if (item.reinit_ok) begin
						nxt.fail_count    = 4'd0;
						nxt.attempt_count = 4'd0;
					end else if (att_inc == regs.recovery_limit) begin
						nxt.off_flag = 1'b1;
					end
				end
			end
		end
	end

	always_comb begin
		res.pos_x       = nxt.held_x;
		res.pos_y       = nxt.held_y;
		res.pressed     = nxt.held_press;
		res.touch_off   = nxt.off_flag;
		res.recover_now = recovered;
		res.fail_stage  = stage;
	end
endmodule
`default_nettype wire

// ===== src/touch_report_recovery_fsm.sv =====
// Top level of the touch report tracker with failure budget and recovery control.
//
// Usage: each beat on the poll channel is either a poll outcome (status, point
// and clear results plus the reinit outcome) or a time tick. Every accepted beat
// yields exactly one beat on the pointer channel carrying the held landscape
// point, the press flag, the touch-disabled flag, whether a recovery was made
// and which transfer failed. Configuration writes go through the cfg channel,
// which is always ready, and must only be issued while the block is idle.
// An accepted poll beat is first held in the input register, then the decode
// and budget logic loads the result register together with the tracking
// state. Throughput is one beat per cycle while the pointer receiver does not
// stall. When it stalls, the result register holds its beat and the input
// register still takes one more beat if it is empty before poll ready drops.
// Reset clears the tracking state, empties both registers and loads the
// default configuration: three failures, two recoveries, 2000 ticks, five
// points.
`default_nettype none
module touch_report_recovery_fsm (
	input  wire logic  clk,
	input  wire logic  arst_n,
	trrf_in_if.sink    poll,
	trrf_out_if.source pointer,
	trrf_cfg_if.sink   cfg
);
	import trrf_pkg::*;

	cfg_regs_t    regs;
	track_state_t state_q;
	track_state_t state_nxt;
	out_item_t    res;
	in_item_t     item_s1;
	logic         valid_s1;
	out_item_t    out_q;
	logic         out_valid_q;
	logic         advance;

	trrf_cfg_regs u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.regs   (regs)
	);

	trrf_step u_step (
		.item (item_s1),
		.regs (regs),
		.cur  (state_q),
		.nxt  (state_nxt),
		.res  (res)
	);

	assign advance      = valid_s1 && (!out_valid_q || pointer.ready);
	assign poll.ready   = !valid_s1 || advance;
	assign pointer.valid = out_valid_q;
	assign pointer.data  = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (poll.ready) begin
			valid_s1 <= poll.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (poll.ready && poll.valid) begin
			item_s1 <= poll.data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			state_q     <= '0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
			state_q     <= state_nxt;
		end else if (pointer.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_q <= res;
		end
	end

	a_recover_has_stage: assert property (@(posedge clk) disable iff (!arst_n)
		(pointer.valid && pointer.data.recover_now) |-> (pointer.data.fail_stage != STAGE_NONE))
		else $error("recovery reported without a failed transfer");

	a_off_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.off_flag |=> state_q.off_flag)
		else $error("touch disable flag cleared");

	a_off_released: assert property (@(posedge clk) disable iff (!arst_n)
		(pointer.valid && pointer.data.touch_off) |-> !pointer.data.pressed)
		else $error("press reported while touch is disabled");

	a_coord_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.held_y <= RAW_X_MAX[7:0])
		else $error("held y beyond panel range");
endmodule
`default_nettype wire

// ===== bench/trrf_pointer_checker.sv =====
// Checker that tracks the touch recovery state and compares every pointer beat.
`timescale 1ns / 1ps
`default_nettype none
module trrf_pointer_checker
	import trrf_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	trrf_in_if        poll,
	trrf_out_if       pointer,
	trrf_cfg_if       cfg,
	output int        mismatches,
	output int        outstanding,
	output int        checked,
	output int        recoveries
);

	cfg_regs_t    regs;
	track_state_t st;
	out_item_t    pointer_expect_q[$];
	out_item_t    want;
	out_item_t    got;
	out_item_t    next_pointer;

	initial begin
		mismatches  = 0;
		outstanding = 0;
		checked     = 0;
		recoveries  = 0;
	end

	function automatic void clear_budget();
		st.fail_count    = 4'd0;
		st.attempt_count = 4'd0;
	endfunction

	function automatic logic charge_failure(input logic reinit_ok);
		st.held_press = 1'b0;
		if (st.off_flag)
			return 1'b0;
		if (st.fail_count != COUNT_SAT)
			st.fail_count = st.fail_count + 4'd1;
		if (st.fail_count < regs.failure_limit)
			return 1'b0;
		if (st.holdoff_left != 16'd0)
			return 1'b0;
		if (st.attempt_count >= regs.recovery_limit) begin
			st.off_flag = 1'b1;
			return 1'b0;
		end
		st.attempt_count = st.attempt_count + 4'd1;
		st.holdoff_left  = regs.holdoff_ticks;
		if (reinit_ok)
			clear_budget();
		else if (st.attempt_count == regs.recovery_limit)
			st.off_flag = 1'b1;
		return 1'b1;
	endfunction

	function automatic out_item_t track_poll(input in_item_t it);
		out_item_t   res;
		logic [3:0]  count;
		logic [15:0] cx;
		logic [15:0] cy;
		logic [15:0] flipped;
		logic [1:0]  stage;
		logic        recovered;
		logic        failed;
		stage     = STAGE_NONE;
		recovered = 1'b0;
		failed    = 1'b0;
		count     = it.status_byte[3:0];
		if (it.command == CMD_TICK) begin
			if (st.holdoff_left != 16'd0)
				st.holdoff_left = st.holdoff_left - 16'd1;
		end else if (st.off_flag) begin
			st.held_press = 1'b0;
		end else if (!it.status_ok) begin
			stage     = STAGE_STATUS;
			recovered = charge_failure(it.reinit_ok);
		end else if (!it.status_byte[STATUS_READY_BIT]) begin
			clear_budget();
		end else begin
			if (count >= 4'd1 && count <= regs.max_points) begin
				if (!it.point_ok) begin
					stage     = STAGE_POINT;
					recovered = charge_failure(it.reinit_ok);
					failed    = 1'b1;
				end else begin
					cx            = (it.raw_x > RAW_X_MAX) ? RAW_X_MAX : it.raw_x;
					cy            = (it.raw_y > RAW_Y_MAX) ? RAW_Y_MAX : it.raw_y;
					flipped       = RAW_Y_MAX - cy;
					st.held_y     = cx[7:0];
					st.held_x     = flipped[8:0];
					st.held_press = 1'b1;
				end
			end else begin
				st.held_press = 1'b0;
			end
			if (!failed) begin
				if (!it.clear_ok) begin
					stage     = STAGE_CLEAR;
					recovered = charge_failure(it.reinit_ok);
				end else begin
					clear_budget();
				end
			end
		end
		res.pos_x       = st.held_x;
		res.pos_y       = st.held_y;
		res.pressed     = st.held_press;
		res.touch_off   = st.off_flag;
		res.recover_now = recovered;
		res.fail_stage  = stage;
		return res;
	endfunction

	function automatic void note_field(input string field, input logic [15:0] exp_v,
			input logic [15:0] act_v);
		if (act_v !== exp_v) begin
			$error("%s mismatch: expected %0d, actual %0d", field, exp_v, act_v);
			mismatches++;
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs.failure_limit  = FAILURE_LIMIT_RST;
			regs.recovery_limit = RECOVERY_LIMIT_RST;
			regs.holdoff_ticks  = HOLDOFF_TICKS_RST;
			regs.max_points     = MAX_POINTS_RST;
			st                  = '0;
			pointer_expect_q.delete();
			outstanding         = 0;
		end else begin
			if (cfg.valid && cfg.ready) begin
				case (cfg.data.index)
					REG_FAILURE_LIMIT:  regs.failure_limit  = cfg.data.value[3:0];
					REG_RECOVERY_LIMIT: regs.recovery_limit = cfg.data.value[3:0];
					REG_HOLDOFF_TICKS:  regs.holdoff_ticks  = cfg.data.value;
					REG_MAX_POINTS:     regs.max_points     = cfg.data.value[3:0];
					default: ;
				endcase
			end
			if (pointer.valid && pointer.ready) begin
				got = pointer.data;
				if (pointer_expect_q.size() == 0) begin
					$error("Pointer beat arrived with no poll beat pending.");
					mismatches++;
				end else begin
					want = pointer_expect_q.pop_front();
					checked++;
					note_field("pos_x", 16'(want.pos_x), 16'(got.pos_x));
					note_field("pos_y", 16'(want.pos_y), 16'(got.pos_y));
					note_field("pressed", 16'(want.pressed), 16'(got.pressed));
					note_field("touch_off", 16'(want.touch_off), 16'(got.touch_off));
					note_field("recover_now", 16'(want.recover_now), 16'(got.recover_now));
					note_field("fail_stage", 16'(want.fail_stage), 16'(got.fail_stage));
				end
			end
			if (poll.valid && poll.ready) begin
				next_pointer = track_poll(poll.data);
				if (next_pointer.recover_now)
					recoveries++;
				pointer_expect_q.push_back(next_pointer);
			end
			outstanding = pointer_expect_q.size();
		end
	end

	final begin
		if (pointer_expect_q.size() != 0)
			$error("%0d pointer beats never arrived.", pointer_expect_q.size());
	end

endmodule
`default_nettype wire

// ===== bench/tb_touch_report_recovery_fsm.sv =====
// Testbench top for the touch recovery block: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps
`default_nettype none
module tb_touch_report_recovery_fsm;
	import trrf_pkg::*;

	logic clk;
	logic arst_n;
	bit   steady;
	int   mismatches;
	int   outstanding;
	int   checked;
	int   recoveries;
	int   sent;
	logic [3:0] cur_max_points;

	trrf_in_if  poll_if ();
	trrf_out_if ptr_if ();
	trrf_cfg_if cfg_if ();

	touch_report_recovery_fsm dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.poll    (poll_if),
		.pointer (ptr_if),
		.cfg     (cfg_if)
	);

	trrf_pointer_checker budget_check (
		.clk         (clk),
		.arst_n      (arst_n),
		.poll        (poll_if),
		.pointer     (ptr_if),
		.cfg         (cfg_if),
		.mismatches  (mismatches),
		.outstanding (outstanding),
		.checked     (checked),
		.recoveries  (recoveries)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		#4_000_000;
		$display("Some tests failed");
		$finish;
	end

	initial begin
		ptr_if.ready = 1'b0;
		forever begin
			@(negedge clk);
			ptr_if.ready = steady || ($urandom_range(99) >= 22);
		end
	end

	function automatic in_item_t make_poll(input logic sok, input logic [7:0] sbyte,
			input logic pok, input logic [15:0] x, input logic [15:0] y,
			input logic cok, input logic rok);
		in_item_t it;
		it.command     = CMD_POLL;
		it.status_ok   = sok;
		it.status_byte = sbyte;
		it.point_ok    = pok;
		it.raw_x       = x;
		it.raw_y       = y;
		it.clear_ok    = cok;
		it.reinit_ok   = rok;
		return it;
	endfunction

	function automatic in_item_t random_item(input int tick_pct, input int reinit_pct);
		in_item_t it;
		it.command     = ($urandom_range(99) < tick_pct) ? CMD_TICK : CMD_POLL;
		it.status_ok   = $urandom_range(99) < 88;
		it.status_byte = 8'($urandom);
		it.status_byte[STATUS_READY_BIT] = $urandom_range(99) < 85;
		if (cur_max_points != 4'd0 && $urandom_range(99) < 70)
			it.status_byte[3:0] = 4'($urandom_range(cur_max_points, 1));
		it.point_ok    = $urandom_range(99) < 88;
		it.clear_ok    = $urandom_range(99) < 88;
		it.reinit_ok   = $urandom_range(99) < reinit_pct;
		if ($urandom_range(1)) begin
			it.raw_x = 16'($urandom_range(300));
			it.raw_y = 16'($urandom_range(400));
		end else begin
			it.raw_x = 16'($urandom);
			it.raw_y = 16'($urandom);
		end
		return it;
	endfunction

	task automatic send_poll(input in_item_t it);
		while (!steady && $urandom_range(99) < 22) begin
			poll_if.valid = 1'b0;
			poll_if.data  = random_item(50, 50);
			@(negedge clk);
		end
		poll_if.valid = 1'b1;
		poll_if.data  = it;
		do @(posedge clk); while (!poll_if.ready);
		@(negedge clk);
		sent++;
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [15:0] value);
		cfg_if.valid      = 1'b1;
		cfg_if.data.index = idx;
		cfg_if.data.value = value;
		do @(posedge clk); while (!cfg_if.ready);
		@(negedge clk);
		cfg_if.valid = 1'b0;
	endtask

	task automatic drain();
		poll_if.valid = 1'b0;
		wait (outstanding == 0);
		repeat (4) @(negedge clk);
	endtask

	task automatic apply_setting(input logic [3:0] fail_lim, input logic [3:0] rec_lim,
			input logic [15:0] hold, input logic [3:0] max_pts);
		drain();
		write_reg(REG_FAILURE_LIMIT, {12'($urandom), fail_lim});
		write_reg(REG_RECOVERY_LIMIT, {12'($urandom), rec_lim});
		write_reg(REG_HOLDOFF_TICKS, hold);
		write_reg(REG_MAX_POINTS, {12'($urandom), max_pts});
		cur_max_points = max_pts;
	endtask

	task automatic run_phase(input int items, input int tick_pct, input int reinit_pct);
		int       n;
		in_item_t it;
		n = 0;
		while (n < items) begin
			if ($urandom_range(99) < 12) begin
				// A run of failing polls with ticks mixed in drives the budget deep.
				repeat ($urandom_range(18, 2)) begin
					it = random_item(tick_pct / 2, reinit_pct);
					if (it.command == CMD_POLL) begin
						it.status_ok = 1'b1;
						it.status_byte[STATUS_READY_BIT] = 1'b1;
						case ($urandom_range(2))
							0: it.status_ok = 1'b0;
							1: begin
								if (cur_max_points != 4'd0) begin
									it.status_byte[3:0] = 4'($urandom_range(cur_max_points, 1));
									it.point_ok = 1'b0;
								end else begin
									it.status_ok = 1'b0;
								end
							end
							default: begin
								it.point_ok = 1'b1;
								it.clear_ok = 1'b0;
							end
						endcase
					end
					send_poll(it);
					n++;
				end
			end else begin
				send_poll(random_item(tick_pct, reinit_pct));
				n++;
			end
		end
	endtask

	initial begin
		in_item_t tick;
		tick           = '0;
		tick.command   = CMD_TICK;
		sent           = 0;
		steady         = 1'b0;
		cur_max_points = MAX_POINTS_RST;
		arst_n         = 1'b0;
		poll_if.valid  = 1'b0;
		poll_if.data   = '0;
		cfg_if.valid   = 1'b0;
		cfg_if.data    = '0;
		repeat (10) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		send_poll(tick);
		send_poll(make_poll(1'b1, 8'h81, 1'b1, 16'd0, 16'd0, 1'b1, 1'b0));
		send_poll(make_poll(1'b1, 8'h85, 1'b1, 16'hFFFF, 16'hFFFF, 1'b1, 1'b0));
		send_poll(make_poll(1'b1, 8'hF1, 1'b1, 16'd239, 16'd319, 1'b1, 1'b1));
		send_poll(make_poll(1'b1, 8'h81, 1'b1, 16'd240, 16'd320, 1'b1, 1'b0));
		send_poll(make_poll(1'b1, 8'h05, 1'b1, 16'd7, 16'd9, 1'b1, 1'b0));
		send_poll(make_poll(1'b1, 8'h80, 1'b1, 16'd7, 16'd9, 1'b1, 1'b0));
		send_poll(make_poll(1'b1, 8'h86, 1'b1, 16'd7, 16'd9, 1'b1, 1'b0));
		send_poll(make_poll(1'b1, 8'h8F, 1'b1, 16'd7, 16'd9, 1'b1, 1'b0));
		send_poll(make_poll(1'b0, 8'h81, 1'b1, 16'd1, 16'd2, 1'b1, 1'b0));
		send_poll(make_poll(1'b1, 8'h82, 1'b0, 16'd1, 16'd2, 1'b1, 1'b0));
		send_poll(make_poll(1'b1, 8'h83, 1'b1, 16'd100, 16'd200, 1'b0, 1'b1));
		send_poll(make_poll(1'b0, 8'h81, 1'b1, 16'd1, 16'd2, 1'b1, 1'b0));
		send_poll(make_poll(1'b0, 8'h81, 1'b1, 16'd1, 16'd2, 1'b1, 1'b0));
		send_poll(make_poll(1'b0, 8'h81, 1'b1, 16'd1, 16'd2, 1'b1, 1'b0));
		send_poll(tick);

		run_phase(90, 40, 70);

		apply_setting(4'd0, 4'd15, 16'd0, 4'd0);
		steady = 1'b1;
		run_phase(110, 20, 90);
		steady = 1'b0;

		apply_setting(4'd15, 4'd15, 16'hFFFF, 4'd15);
		run_phase(55, 20, 80);
		drain();
		run_phase(55, 20, 80);

		apply_setting(4'd1, 4'd3, 16'd5, 4'd1);
		run_phase(110, 35, 75);

		apply_setting(4'd2, 4'd0, 16'd1, 4'd15);
		run_phase(110, 25, 50);

		drain();
		repeat (10) @(negedge clk);
		$display("Run covered %0d poll and tick beats over five register settings.", sent);
		$display("Checked %0d pointer beats, %0d of them with a recovery.", checked, recoveries);
		if (mismatches == 0 && outstanding == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
`default_nettype wire

// ===== sim.f =====
src/trrf_pkg.sv
src/trrf_ifs.sv
src/trrf_cfg_regs.sv
src/trrf_step.sv
src/touch_report_recovery_fsm.sv
bench/trrf_pointer_checker.sv
bench/tb_touch_report_recovery_fsm.sv
